// ----- rtl/core/satd_hadamard_4x4_accumulator_unit_assert.svh -----
// Assertion macros shared by the SATD accumulator RTL.
`ifndef SATD_HADAMARD_4X4_ACCUMULATOR_UNIT_ASSERT_SVH
`define SATD_HADAMARD_4X4_ACCUMULATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SATD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("SATD same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define SATD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("SATD next-cycle check failed");
`else
`define SATD_ASSERT_NOW(label, clk, rst, ante, cons)
`define SATD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/satd_pkg.sv -----
// Types and constants of the SATD 4x4 Hadamard accumulator.
package satd_pkg;

   localparam int IN_BITS    = 16;
   localparam int PIXEL_BITS = 16;
   localparam int ROWS       = 4;
   localparam int COLS       = 4;
   localparam int ROW_BITS   = 2;
   localparam int PEND_ROWS  = ROWS - 1;
   localparam int PAIRS      = 8;

   localparam int DIFF_BITS  = PIXEL_BITS + 1;
   localparam int T_BITS     = DIFF_BITS + 1;
   localparam int H_BITS     = DIFF_BITS + 2;
   localparam int U_BITS     = DIFF_BITS + 3;
   localparam int MAG_BITS   = U_BITS;
   localparam int SUM_BITS   = MAG_BITS + 3;
   localparam int TOTAL_BITS = 40;
   localparam int OUT_BITS   = 32;

   localparam logic [OUT_BITS-1:0] OUT_MAX = 32'hFFFF_FFFF;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
   localparam logic [ROW_BITS-1:0] LAST_ROW = ROW_BITS'(ROWS - 1);

   typedef logic [IN_BITS-1:0]          pixel_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;
   typedef logic signed [U_BITS-1:0]    coef_type;
   typedef logic [MAG_BITS-1:0]         mag_type;
   typedef logic [SUM_BITS-1:0]         sum_type;
   typedef logic [TOTAL_BITS-1:0]       total_type;
   typedef logic [OUT_BITS-1:0]         out_type;

   typedef diff_type tile_type [ROWS][COLS];
   typedef coef_type coef_blk_type [ROWS][COLS];
   typedef mag_type  mag_set_type [PAIRS];

   typedef struct packed {
      logic valid;
      logic last;
   } tile_ctl_type;

endpackage

// ----- rtl/core/satd_if.sv -----
// Request and response channel interfaces of the SATD accumulator.
interface satd_req_if;
   logic                 valid;
   logic                 ready;
   satd_pkg::pixel_type  src_pixel_0;
   satd_pkg::pixel_type  src_pixel_1;
   satd_pkg::pixel_type  src_pixel_2;
   satd_pkg::pixel_type  src_pixel_3;
   satd_pkg::pixel_type  ref_pixel_0;
   satd_pkg::pixel_type  ref_pixel_1;
   satd_pkg::pixel_type  ref_pixel_2;
   satd_pkg::pixel_type  ref_pixel_3;
   logic                 end_of_block;

   modport source (output valid, src_pixel_0, src_pixel_1, src_pixel_2, src_pixel_3,
                   ref_pixel_0, ref_pixel_1, ref_pixel_2, ref_pixel_3, end_of_block,
                   input ready);
   modport sink (input valid, src_pixel_0, src_pixel_1, src_pixel_2, src_pixel_3,
                 ref_pixel_0, ref_pixel_1, ref_pixel_2, ref_pixel_3, end_of_block,
                 output ready);
endinterface

interface satd_rsp_if;
   logic               valid;
   logic               ready;
   satd_pkg::out_type  satd_value;

   modport source (output valid, satd_value, input ready);
   modport sink (input valid, satd_value, output ready);
endinterface

// ----- rtl/core/satd_tile_asm.sv -----
// Row intake: differences, pending rows of the tile and the tile register.
module satd_tile_asm (
   input  logic                    clock,
   input  logic                    reset,
   satd_req_if.sink                req_ch,
   output satd_pkg::tile_ctl_type  tile_ctl,
   output satd_pkg::tile_type      tile,
   input  logic                    tile_ready
);

   logic [satd_pkg::ROW_BITS-1:0] row_ff, row_in;
   satd_pkg::diff_type            pending_ff [satd_pkg::PEND_ROWS][satd_pkg::COLS];
   satd_pkg::tile_ctl_type        ctl_ff, ctl_in;
   satd_pkg::tile_type            tile_ff, tile_in;
   satd_pkg::diff_type            diff [satd_pkg::COLS];
   logic [satd_pkg::PIXEL_BITS-1:0] src_px [satd_pkg::COLS];
   logic [satd_pkg::PIXEL_BITS-1:0] ref_px [satd_pkg::COLS];
   logic                          accept;
   logic                          complete;

   // Bits above the pixel width are dropped here.
   assign src_px[0] = req_ch.src_pixel_0[satd_pkg::PIXEL_BITS-1:0];
   assign src_px[1] = req_ch.src_pixel_1[satd_pkg::PIXEL_BITS-1:0];
   assign src_px[2] = req_ch.src_pixel_2[satd_pkg::PIXEL_BITS-1:0];
   assign src_px[3] = req_ch.src_pixel_3[satd_pkg::PIXEL_BITS-1:0];
   assign ref_px[0] = req_ch.ref_pixel_0[satd_pkg::PIXEL_BITS-1:0];
   assign ref_px[1] = req_ch.ref_pixel_1[satd_pkg::PIXEL_BITS-1:0];
   assign ref_px[2] = req_ch.ref_pixel_2[satd_pkg::PIXEL_BITS-1:0];
   assign ref_px[3] = req_ch.ref_pixel_3[satd_pkg::PIXEL_BITS-1:0];

   assign req_ch.ready = !ctl_ff.valid || tile_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign complete     = (row_ff == satd_pkg::LAST_ROW) || req_ch.end_of_block;

   always_comb begin
      for (int c = 0; c < satd_pkg::COLS; c++) begin
         diff[c] = $signed({1'b0, src_px[c]}) - $signed({1'b0, ref_px[c]});
      end
   end

   // Earlier rows from storage, current row from the port, later rows zero.
   always_comb begin
      for (int r = 0; r < satd_pkg::PEND_ROWS; r++) begin
         for (int c = 0; c < satd_pkg::COLS; c++) begin
            if (satd_pkg::ROW_BITS'(r) < row_ff) begin
               tile_in[r][c] = pending_ff[r][c];
            end else if (satd_pkg::ROW_BITS'(r) == row_ff) begin
               tile_in[r][c] = diff[c];
            end else begin
               tile_in[r][c] = '0;
            end
         end
      end
      for (int c = 0; c < satd_pkg::COLS; c++) begin
         tile_in[satd_pkg::ROWS-1][c] = (row_ff == satd_pkg::LAST_ROW) ? diff[c] : '0;
      end
   end

   always_comb begin
      row_in = row_ff;
      ctl_in = ctl_ff;
      if (tile_ready) begin
         ctl_in.valid = 1'b0;
      end
      if (accept) begin
         row_in = complete ? '0 : row_ff + 1'b1;
         if (complete) begin
            ctl_in.valid = 1'b1;
            ctl_in.last  = req_ch.end_of_block;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         ctl_ff <= '0;
      end else begin
         row_ff <= row_in;
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && complete) begin
         tile_ff <= tile_in;
      end
      if (accept && !complete) begin
         pending_ff[row_ff] <= diff;
      end
   end

   assign tile_ctl = ctl_ff;
   assign tile     = tile_ff;

endmodule

// ----- rtl/core/satd_xform.sv -----
// Hadamard transform pipeline: butterflies, pairwise max, tile sum.
module satd_xform (
   input  logic                    clock,
   input  logic                    reset,
   input  satd_pkg::tile_ctl_type  in_ctl,
   input  satd_pkg::tile_type      in_tile,
   output logic                    in_ready,
   output satd_pkg::tile_ctl_type  sum_ctl,
   output satd_pkg::sum_type       sum_value,
   input  logic                    sum_ready
);

   satd_pkg::tile_ctl_type ctl2_ff, ctl2_in, ctl3_ff, ctl3_in, ctl4_ff, ctl4_in;
   satd_pkg::coef_blk_type coef_ff, coef_in;
   satd_pkg::mag_set_type  pmax_ff, pmax_in;
   satd_pkg::sum_type      sum_ff, sum_in;
   logic                   rdy2, rdy3, rdy4;

   assign rdy4     = !ctl4_ff.valid || sum_ready;
   assign rdy3     = !ctl3_ff.valid || rdy4;
   assign rdy2     = !ctl2_ff.valid || rdy3;
   assign in_ready = rdy2;

   // Column butterflies then row butterflies.
   always_comb begin
      logic signed [satd_pkg::T_BITS-1:0] t0, t1, t2, t3;
      logic signed [satd_pkg::H_BITS-1:0] h [satd_pkg::ROWS][satd_pkg::COLS];
      for (int c = 0; c < satd_pkg::COLS; c++) begin
         t0 = satd_pkg::T_BITS'(in_tile[0][c]) + satd_pkg::T_BITS'(in_tile[1][c]);
         t1 = satd_pkg::T_BITS'(in_tile[0][c]) - satd_pkg::T_BITS'(in_tile[1][c]);
         t2 = satd_pkg::T_BITS'(in_tile[2][c]) + satd_pkg::T_BITS'(in_tile[3][c]);
         t3 = satd_pkg::T_BITS'(in_tile[2][c]) - satd_pkg::T_BITS'(in_tile[3][c]);
         h[0][c] = satd_pkg::H_BITS'(t0) + satd_pkg::H_BITS'(t2);
         h[1][c] = satd_pkg::H_BITS'(t1) + satd_pkg::H_BITS'(t3);
         h[2][c] = satd_pkg::H_BITS'(t0) - satd_pkg::H_BITS'(t2);
         h[3][c] = satd_pkg::H_BITS'(t1) - satd_pkg::H_BITS'(t3);
      end
      for (int r = 0; r < satd_pkg::ROWS; r++) begin
         coef_in[r][0] = satd_pkg::U_BITS'(h[r][0]) + satd_pkg::U_BITS'(h[r][1]);
         coef_in[r][1] = satd_pkg::U_BITS'(h[r][0]) - satd_pkg::U_BITS'(h[r][1]);
         coef_in[r][2] = satd_pkg::U_BITS'(h[r][2]) + satd_pkg::U_BITS'(h[r][3]);
         coef_in[r][3] = satd_pkg::U_BITS'(h[r][2]) - satd_pkg::U_BITS'(h[r][3]);
      end
   end

   // |x+y| + |x-y| = 2 max(|x|,|y|): keep the max, which is the halved pair.
   always_comb begin
      satd_pkg::mag_type m [satd_pkg::COLS];
      for (int r = 0; r < satd_pkg::ROWS; r++) begin
         for (int c = 0; c < satd_pkg::COLS; c++) begin
            m[c] = satd_pkg::mag_type'((coef_ff[r][c] < 0) ? -coef_ff[r][c] : coef_ff[r][c]);
         end
         pmax_in[2*r]     = (m[0] > m[2]) ? m[0] : m[2];
         pmax_in[2*r + 1] = (m[1] > m[3]) ? m[1] : m[3];
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < satd_pkg::PAIRS; i++) begin
         sum_in = sum_in + satd_pkg::SUM_BITS'(pmax_ff[i]);
      end
   end

   always_comb begin
      ctl2_in = rdy2 ? in_ctl  : ctl2_ff;
      ctl3_in = rdy3 ? ctl2_ff : ctl3_ff;
      ctl4_in = rdy4 ? ctl3_ff : ctl4_ff;
      if (rdy2 && !in_ctl.valid) begin
         ctl2_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else begin
         ctl2_ff <= ctl2_in;
         ctl3_ff <= ctl3_in;
         ctl4_ff <= ctl4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && in_ctl.valid) begin
         coef_ff <= coef_in;
      end
      if (rdy3 && ctl2_ff.valid) begin
         pmax_ff <= pmax_in;
      end
      if (rdy4 && ctl3_ff.valid) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_ctl   = ctl4_ff;
   assign sum_value = sum_ff;

endmodule

// ----- rtl/core/satd_accum.sv -----
// Block total accumulator and response register.
module satd_accum (
   input  logic                    clock,
   input  logic                    reset,
   input  satd_pkg::tile_ctl_type  sum_ctl,
   input  satd_pkg::sum_type       sum_value,
   output logic                    sum_ready,
   satd_rsp_if.source              rsp_ch
);

   satd_pkg::total_type            total_ff, total_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   satd_pkg::out_type              value_ff, value_in;
   logic [satd_pkg::TOTAL_BITS:0]  wide_sum;
   satd_pkg::total_type            sat_total;
   logic                           take;

   // A tile that closes a block waits for the response slot; others pass freely.
   assign sum_ready = !sum_ctl.last || !rsp_valid_ff || rsp_ch.ready;
   assign take      = sum_ctl.valid && sum_ready;

   assign wide_sum  = {1'b0, total_ff} + (satd_pkg::TOTAL_BITS + 1)'(sum_value);
   assign sat_total = wide_sum[satd_pkg::TOTAL_BITS] ? satd_pkg::TOTAL_MAX
                                                     : wide_sum[satd_pkg::TOTAL_BITS-1:0];

   always_comb begin
      total_in     = total_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (take) begin
         if (sum_ctl.last) begin
            total_in     = '0;
            rsp_valid_in = 1'b1;
            value_in     = (|sat_total[satd_pkg::TOTAL_BITS-1:satd_pkg::OUT_BITS])
                           ? satd_pkg::OUT_MAX : sat_total[satd_pkg::OUT_BITS-1:0];
         end else begin
            total_in = sat_total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.satd_value = value_ff;

endmodule

// ----- rtl/core/satd_hadamard_4x4_accumulator_unit.sv -----
// SATD accumulator over 4x4 Hadamard tiles: top level.
//
// req_ch carries one tile row per transaction: four source and four reference
// pixels and end_of_block. Four rows make a tile; each finished tile is
// transformed with the 2D 4-point Hadamard and half its absolute coefficient
// sum is added to a 40-bit saturating block total. A row with end_of_block set
// closes the tile early (missing rows count as zero difference) and yields one
// rsp_ch transaction carrying the total clamped to 32 bits, then the total and
// row position clear.
// Throughput: one row per cycle unless the pipeline stalls. A closing row passes
// the tile register, butterflies, pairwise max, tile sum and accumulate/response
// register stages in that order before its response is valid.
// Rows that do not close a tile only update the row position and pending rows.
// Reset (synchronous) empties the pipeline, clears the total and row position;
// pending row contents are left as they are and never read before rewritten.
// When the receiver stalls, the waiting response holds; tiles keep flowing
// into the pipeline stages and non-final tiles keep accumulating until a
// closing tile reaches the accumulator, after which stages fill and req_ch.ready
// drops.
`include "satd_hadamard_4x4_accumulator_unit_assert.svh"

module satd_hadamard_4x4_accumulator_unit (
   input  logic       clock,
   input  logic       reset,
   satd_req_if.sink   req_ch,
   satd_rsp_if.source rsp_ch
);

   satd_pkg::tile_ctl_type tile_ctl;
   satd_pkg::tile_type     tile;
   logic                   tile_ready;
   satd_pkg::tile_ctl_type sum_ctl;
   satd_pkg::sum_type      sum_value;
   logic                   sum_ready;

   // Row intake and tile assembly.
   satd_tile_asm u_tile_asm (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .tile_ctl   (tile_ctl),
      .tile       (tile),
      .tile_ready (tile_ready)
   );

   // Transform and per-tile halved sum.
   satd_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (tile_ctl),
      .in_tile   (tile),
      .in_ready  (tile_ready),
      .sum_ctl   (sum_ctl),
      .sum_value (sum_value),
      .sum_ready (sum_ready)
   );

   // Block total and response register.
   satd_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .sum_ctl   (sum_ctl),
      .sum_value (sum_value),
      .sum_ready (sum_ready),
      .rsp_ch    (rsp_ch)
   );

   // A closing row always produces a closing tile in the next cycle.
   `SATD_ASSERT_NEXT(a_eob_makes_tile, clock, reset,
      req_ch.valid && req_ch.ready && req_ch.end_of_block,
      tile_ctl.valid && tile_ctl.last)
   // A closing tile taken by the accumulator raises a response.
   `SATD_ASSERT_NEXT(a_last_makes_rsp, clock, reset,
      sum_ctl.valid && sum_ready && sum_ctl.last, rsp_ch.valid)
   // The transform only backs up when its output is held by the accumulator.
   `SATD_ASSERT_NOW(a_xform_stall_cause, clock, reset,
      !tile_ready, sum_ctl.valid && !sum_ready)
   // Intake never overwrites a tile that the transform has not taken.
   `SATD_ASSERT_NOW(a_no_tile_overrun, clock, reset,
      req_ch.valid && req_ch.ready, !tile_ctl.valid || tile_ready)

endmodule
